// ----- sv/linear_svm_score_and_update_top_assert.svh -----
// Assertion macros for the checks in the top-level module.
`ifndef LINEAR_SVM_SCORE_AND_UPDATE_TOP_ASSERT_SVH
`define LINEAR_SVM_SCORE_AND_UPDATE_TOP_ASSERT_SVH

`define LSVM_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define LSVM_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ----- sv/lsvm_pkg.sv -----
`default_nettype none
package lsvm_pkg;

   localparam logic [1:0] KIND_SCORE  = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] feature;
      logic               last;
      logic signed [15:0] step;
      logic [63:0]        key;
      logic               match;
   } item_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_FIN,
      ST_SCAN,
      ST_DRAIN,
      ST_CALC,
      ST_COMMIT
   } back_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/lsvm_if.sv -----
`default_nettype none
interface lsvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [15:0] feature_value;
   logic               is_last;
   logic signed [15:0] step_size;
   logic signed [63:0] pattern_key;
   logic [15:0]        true_class;
   logic [15:0]        guessed_class;

   modport source (output valid, req_type, feature_value, is_last, step_size, pattern_key,
                   true_class, guessed_class, input ready);
   modport sink (input valid, req_type, feature_value, is_last, step_size, pattern_key,
                 true_class, guessed_class, output ready);
endinterface

interface lsvm_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic signed [31:0] score;
   logic signed [31:0] gradient;
   logic signed [31:0] coefficient;
   logic               is_support;
   logic [8:0]         support_count;
   logic               table_full;

   modport source (output valid, result_kind, score, gradient, coefficient, is_support,
                   support_count, table_full, input ready);
   modport sink (input valid, result_kind, score, gradient, coefficient, is_support,
                 support_count, table_full, output ready);
endinterface

interface lsvm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] erase_threshold;

   modport source (output valid, erase_threshold, input ready);
   modport sink (input valid, erase_threshold, output ready);
endinterface
`default_nettype wire

// ----- sv/linear_svm_score_and_update_top.sv -----
// Linear SVM scoring and update engine.
// req_ch carries one feature element per transaction (score or update) or a
// coefficient query; rsp_ch returns one transaction for the last element of a
// vector and for each query; csr_ch writes the erase threshold and is always ready.
// A two-entry queue takes requests while the engine works on earlier ones.
// Each score or update element passes through the engine in order: weight memory
// read, multiply, then accumulate or weight write-back.
// The last update element and each query scan the coefficient table one
// entry per cycle, then pass through the drain, calc and commit states.
// After reset the engine clears every word of the weight memory;
// req_ch.ready stays low during that pass, and the table starts empty.
// When the receiver stalls, the result waits in the output register and the
// engine keeps going until it has its next result to deliver.
`default_nettype none
module linear_svm_score_and_update_top
   import lsvm_pkg::*;
#(
   parameter int NUM_FEATURES = 1024,
   parameter int MAX_PATTERNS = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   lsvm_req_if.sink  req_ch,
   lsvm_rsp_if.source rsp_ch,
   lsvm_csr_if.sink  csr_ch
);

   `include "linear_svm_score_and_update_top_assert.svh"

   logic [15:0] thr_ff, thr_in;
   item_type    q_item;
   logic        q_valid;
   logic        q_pop;
   logic        clearing;

   assign csr_ch.ready = 1'b1;
   assign thr_in = csr_ch.valid ? csr_ch.erase_threshold : thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 16'd1;
      end else begin
         thr_ff <= thr_in;
      end
   end

   lsvm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .req      (req_ch),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   lsvm_back #(
      .NUM_FEATURES (NUM_FEATURES),
      .MAX_PATTERNS (MAX_PATTERNS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .erase_threshold (thr_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .clearing        (clearing),
      .rsp             (rsp_ch)
   );

   `LSVM_ASSERT_IMP(a_full_only_update, rsp_ch.valid && rsp_ch.table_full, rsp_ch.result_kind == KIND_UPDATE && !rsp_ch.is_support && rsp_ch.coefficient == 32'sd0, "table_full on a result that dropped nothing")
   `LSVM_ASSERT_IMP(a_score_clean, rsp_ch.valid && rsp_ch.result_kind == KIND_SCORE, !rsp_ch.is_support && rsp_ch.coefficient == 32'sd0, "score result carries coefficient data")
   `LSVM_ASSERT_NEVER(a_no_accept_in_clear, clearing && req_ch.ready, "request accepted during weight clear")
   `LSVM_ASSERT_NEVER(a_no_unused_kind, rsp_ch.valid && rsp_ch.result_kind == KIND_UNUSED, "result for an unused request type")

endmodule
`default_nettype wire

// ----- sv/lsvm_front.sv -----
`default_nettype none
module lsvm_front
   import lsvm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   clearing,
   lsvm_req_if.sink    req,
   output item_type    q_item,
   output logic        q_valid,
   input  wire logic   q_pop
);

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       take;

   assign req.ready = (cnt_ff != 2'd2) && !clearing;
   assign take      = req.valid && req.ready;
   assign push      = take && (req.req_type != KIND_UNUSED);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in.kind    = req.req_type;
      slot_in.feature = req.feature_value;
      slot_in.last    = req.is_last;
      slot_in.step    = req.step_size;
      slot_in.key     = req.pattern_key;
      slot_in.match   = (req.true_class == req.guessed_class);
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/lsvm_back.sv -----
`default_nettype none
module lsvm_back
   import lsvm_pkg::*;
#(
   parameter int NUM_FEATURES = 1024,
   parameter int MAX_PATTERNS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] erase_threshold,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output logic             q_pop,
   output logic             clearing,
   lsvm_rsp_if.source       rsp
);

   localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int CW = $clog2(NUM_FEATURES + 1);
   localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int EW = $clog2(MAX_PATTERNS + 1);
   localparam logic [CW-1:0] NF = CW'(NUM_FEATURES);
   localparam logic [AW-1:0] LAST_W = AW'(NUM_FEATURES - 1);
   localparam logic [PW-1:0] LAST_P = PW'(MAX_PATTERNS - 1);

   logic signed [31:0] weight_mem [NUM_FEATURES];
   logic [63:0]        key_mem [MAX_PATTERNS];
   logic signed [31:0] val_mem [MAX_PATTERNS];

   back_state_type     state_ff, state_in;
   item_type           cur_ff, cur_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [31:0] w_rd_ff;
   logic [AW-1:0]      clr_idx_ff, clr_idx_in;
   logic [PW-1:0]      scan_idx_ff, scan_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [PW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [63:0]        key_rd_ff;
   logic signed [31:0] val_rd_ff;
   logic               found_ff, found_in;
   logic [PW-1:0]      found_idx_ff, found_idx_in;
   logic signed [31:0] found_val_ff, found_val_in;
   logic               free_ff, free_in;
   logic [PW-1:0]      free_idx_ff, free_idx_in;
   logic signed [31:0] nv_ff, nv_in;
   logic [MAX_PATTERNS-1:0] valid_ff, valid_in;
   logic [EW-1:0]      entry_cnt_ff, entry_cnt_in;

   logic               out_vld_ff, out_vld_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic signed [31:0] out_score_ff, out_score_in;
   logic signed [31:0] out_grad_ff, out_grad_in;
   logic signed [31:0] out_coef_ff, out_coef_in;
   logic               out_sup_ff, out_sup_in;
   logic               out_full_ff, out_full_in;

   logic               w_we;
   logic [AW-1:0]      w_wa;
   logic signed [31:0] w_wd;
   logic               t_we;
   logic [PW-1:0]      t_wa;
   logic signed [31:0] t_wd;
   logic               out_free;
   logic signed [47:0] score_prod;
   logic signed [31:0] upd_prod;
   logic signed [47:0] sp;
   logic signed [48:0] acc_sum;
   logic signed [31:0] up;
   logic signed [32:0] w_sum;
   logic signed [31:0] w_new;
   logic signed [31:0] score_c;
   logic signed [32:0] grad_sum;
   logic signed [32:0] coef_sum;
   logic signed [32:0] nv_mag;
   logic               nv_small;

   assign out_free = !out_vld_ff || rsp.ready;
   assign clearing = (state_ff == ST_CLEAR);

   always_comb begin
      score_prod = w_rd_ff * cur_ff.feature;
      upd_prod   = cur_ff.step * cur_ff.feature;
      sp         = prod_ff >>> 12;
      acc_sum    = {acc_ff[47], acc_ff} + {sp[47], sp};
      up         = $signed(prod_ff[31:0]) >>> 8;
      w_sum      = {w_rd_ff[31], w_rd_ff} + {up[31], up};
      w_new      = sat32(w_sum);
      if (acc_ff[47:31] != {17{acc_ff[31]}}) begin
         score_c = acc_ff[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         score_c = acc_ff[31:0];
      end
      grad_sum = (cur_ff.match ? ONE_Q16 : 33'sd0) - {score_c[31], score_c};
      coef_sum = (found_ff ? {found_val_ff[31], found_val_ff} : 33'sd0)
                 + (33'(cur_ff.step) <<< 4);
      nv_mag   = nv_ff[31] ? -{nv_ff[31], nv_ff} : {nv_ff[31], nv_ff};
      nv_small = nv_mag < {17'd0, erase_threshold};
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      clr_idx_in   = clr_idx_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_val_in = found_val_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      nv_in        = nv_ff;
      valid_in     = valid_ff;
      entry_cnt_in = entry_cnt_ff;
      out_vld_in   = out_vld_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_score_in = out_score_ff;
      out_grad_in  = out_grad_ff;
      out_coef_in  = out_coef_ff;
      out_sup_in   = out_sup_ff;
      out_full_in  = out_full_ff;
      q_pop        = 1'b0;
      w_we         = 1'b0;
      w_wa         = cnt_ff[AW-1:0];
      w_wd         = w_new;
      t_we         = 1'b0;
      t_wa         = found_idx_ff;
      t_wd         = nv_ff;

      if (cmp_vld_ff && cmp_valid_ff && (key_rd_ff == cur_ff.key)) begin
         found_in     = 1'b1;
         found_idx_in = cmp_idx_ff;
         found_val_in = val_rd_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            w_we       = 1'b1;
            w_wa       = clr_idx_ff;
            w_wd       = 32'sd0;
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == LAST_W) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (q_item.kind == KIND_QUERY) begin
                  scan_idx_in = '0;
                  found_in    = 1'b0;
                  free_in     = 1'b0;
                  state_in    = ST_SCAN;
               end else if (cnt_ff < NF) begin
                  state_in = ST_MUL;
               end else if (q_item.last) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_MUL: begin
            prod_in  = (cur_ff.kind == KIND_SCORE) ? score_prod : 48'(upd_prod);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (cur_ff.kind == KIND_SCORE) begin
               if (acc_sum[48] != acc_sum[47]) begin
                  acc_in = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  acc_in = acc_sum[47:0];
               end
            end else begin
               w_we = 1'b1;
            end
            cnt_in   = cnt_ff + CW'(1);
            state_in = cur_ff.last ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            if (cur_ff.kind == KIND_SCORE) begin
               if (out_free) begin
                  out_vld_in   = 1'b1;
                  out_kind_in  = KIND_SCORE;
                  out_score_in = score_c;
                  out_grad_in  = sat32(grad_sum);
                  out_coef_in  = 32'sd0;
                  out_sup_in   = 1'b0;
                  out_full_in  = 1'b0;
                  cnt_in       = '0;
                  acc_in       = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               cnt_in      = '0;
               acc_in      = '0;
               scan_idx_in = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmp_vld_in   = 1'b1;
            cmp_idx_in   = scan_idx_ff;
            cmp_valid_in = valid_ff[scan_idx_ff];
            if (!valid_ff[scan_idx_ff] && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = scan_idx_ff;
            end
            scan_idx_in = scan_idx_ff + PW'(1);
            if (scan_idx_ff == LAST_P) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            nv_in    = sat32(coef_sum);
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_kind_in  = cur_ff.kind;
               out_score_in = 32'sd0;
               out_grad_in  = 32'sd0;
               out_coef_in  = 32'sd0;
               out_sup_in   = 1'b0;
               out_full_in  = 1'b0;
               state_in     = ST_IDLE;
               if (cur_ff.kind == KIND_QUERY) begin
                  out_coef_in = found_ff ? found_val_ff : 32'sd0;
                  out_sup_in  = found_ff;
               end else if (nv_small) begin
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     entry_cnt_in           = entry_cnt_ff - EW'(1);
                  end
               end else if (found_ff) begin
                  t_we        = 1'b1;
                  out_coef_in = nv_ff;
                  out_sup_in  = 1'b1;
               end else if (free_ff) begin
                  t_we                  = 1'b1;
                  t_wa                  = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
                  entry_cnt_in          = entry_cnt_ff + EW'(1);
                  out_coef_in           = nv_ff;
                  out_sup_in            = 1'b1;
               end else begin
                  out_full_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_wa] <= w_wd;
      end
      w_rd_ff <= weight_mem[cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (t_we) begin
         val_mem[t_wa] <= t_wd;
      end
      if (t_we && !found_ff) begin
         key_mem[t_wa] <= cur_ff.key;
      end
      key_rd_ff <= key_mem[scan_idx_ff];
      val_rd_ff <= val_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      prod_ff      <= prod_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      cmp_valid_ff <= cmp_valid_in;
      found_idx_ff <= found_idx_in;
      found_val_ff <= found_val_in;
      free_idx_ff  <= free_idx_in;
      nv_ff        <= nv_in;
      out_kind_ff  <= out_kind_in;
      out_score_ff <= out_score_in;
      out_grad_ff  <= out_grad_in;
      out_coef_ff  <= out_coef_in;
      out_sup_ff   <= out_sup_in;
      out_full_ff  <= out_full_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         acc_ff       <= '0;
         clr_idx_ff   <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         valid_ff     <= '0;
         entry_cnt_ff <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         clr_idx_ff   <= clr_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         entry_cnt_ff <= entry_cnt_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   assign rsp.valid         = out_vld_ff;
   assign rsp.result_kind   = out_kind_ff;
   assign rsp.score         = out_score_ff;
   assign rsp.gradient      = out_grad_ff;
   assign rsp.coefficient   = out_coef_ff;
   assign rsp.is_support    = out_sup_ff;
   assign rsp.support_count = 9'(entry_cnt_ff);
   assign rsp.table_full    = out_full_ff;

endmodule
`default_nettype wire
